[hdl/db_value_to_text_formatter_defines.svh]
// Assertion macros used by the formatter back end.
`ifndef DB_VALUE_TO_TEXT_FORMATTER_DEFINES_SVH
`define DB_VALUE_TO_TEXT_FORMATTER_DEFINES_SVH
`ifndef SYNTH
`define VTF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define VTF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VTF_ASSERT(lbl, clk, rstn, prop, msg)
`define VTF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hdl/db_vtf_pkg.sv]
// Types, constants and helper functions of the value to text formatter.
package db_vtf_pkg;

    localparam logic [2:0] KIND_NULL    = 3'd0;
    localparam logic [2:0] KIND_DATE    = 3'd1;
    localparam logic [2:0] KIND_DTIME   = 3'd2;
    localparam logic [2:0] KIND_CHAR    = 3'd3;
    localparam logic [2:0] KIND_VARCHAR = 3'd4;

    localparam logic [63:0] DATE_NULL  = 64'h0000_0000_ffff_fffe;
    localparam logic [63:0] DTIME_NULL = 64'hffff_ffff_ffff_fffe;
    localparam logic [63:0] CHR_NULL_1 = 64'h0000_0000_0000_00fe;
    localparam logic [63:0] CHR_NULL_2 = 64'h0000_0000_0000_feff;
    localparam logic [63:0] CHR_NULL_4 = 64'h0000_0000_feff_ffff;
    localparam logic [63:0] CHR_NULL_8 = 64'hfeff_ffff_ffff_ffff;
    localparam logic [63:0] INT_NULL_8 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT_NULL_4 = 64'h0000_0000_8000_0000;
    localparam logic [63:0] INT_NULL_2 = 64'h0000_0000_0000_8000;
    localparam logic [63:0] INT_NULL_1 = 64'h0000_0000_0000_0080;

    localparam logic [4:0] SCALE_MAX = 5'd18;
    localparam logic [7:0] SEP_RESET = 8'd44;
    localparam logic       REG_SEPARATOR = 1'b0;

    localparam logic [7:0] ASCII_0     = 8'h30;
    localparam logic [7:0] ASCII_DASH  = 8'h2d;
    localparam logic [7:0] ASCII_DOT   = 8'h2e;
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_COLON = 8'h3a;

    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    typedef enum logic [2:0] {
        MODE_NONE, MODE_DATE, MODE_DTIME, MODE_CHARS, MODE_DEC
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CONV, ST_SKIP, ST_TEXT, ST_SEP
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic        neg;
        logic [63:0] value;
        logic [3:0]  count;
        logic [4:0]  scale;
    } t_desc;

    // Tens digit of a value below 64, by multiplication with 13/128.
    function automatic logic [3:0] tens6(input logic [5:0] t);
        logic [9:0] p;
        p = 10'(t) * 10'd13;
        return {1'b0, p[9:7]};
    endfunction

    function automatic logic [3:0] ones6(input logic [5:0] t);
        logic [5:0] q;
        q = 6'(tens6(t)) * 6'd10;
        return 4'(t - q);
    endfunction

    // One double dabble correction over all BCD digits.
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            r[4*k +: 4] = (b[4*k +: 4] >= 4'd5) ? b[4*k +: 4] + 4'd3 : b[4*k +: 4];
        end
        return r;
    endfunction

endpackage

[hdl/db_vtf_if.sv]
// Valid/ready channel interfaces for column values and text bytes.
interface db_vtf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [2:0]  col_kind;
    logic [7:0]  col_width;
    logic [4:0]  scale;
    modport source(output valid, value, col_kind, col_width, scale, input ready);
    modport sink(input valid, value, col_kind, col_width, scale, output ready);
endinterface

interface db_vtf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last;
    modport source(output valid, char_byte, last, input ready);
    modport sink(input valid, char_byte, last, output ready);
endinterface

[hdl/db_vtf_front.sv]
// Front end: accepts column values and classifies them into job descriptors.
module db_vtf_front (
    db_vtf_in_if.sink          i_in,
    input  logic               i_full,
    output logic               o_push,
    output db_vtf_pkg::t_desc  o_desc
);

    logic [63:0] mag;
    logic [63:0] chr_null;
    logic        int_ok;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;
    assign mag        = i_in.value[63] ? (64'd0 - i_in.value) : i_in.value;

    always_comb begin
        case (i_in.col_width)
            8'd1:    chr_null = (i_in.col_kind == db_vtf_pkg::KIND_VARCHAR) ?
                                db_vtf_pkg::CHR_NULL_2 : db_vtf_pkg::CHR_NULL_1;
            8'd2:    chr_null = (i_in.col_kind == db_vtf_pkg::KIND_VARCHAR) ?
                                db_vtf_pkg::CHR_NULL_4 : db_vtf_pkg::CHR_NULL_2;
            8'd3:    chr_null = db_vtf_pkg::CHR_NULL_4;
            8'd4:    chr_null = (i_in.col_kind == db_vtf_pkg::KIND_VARCHAR) ?
                                db_vtf_pkg::CHR_NULL_8 : db_vtf_pkg::CHR_NULL_4;
            default: chr_null = db_vtf_pkg::CHR_NULL_8;
        endcase
    end

    always_comb begin
        case (i_in.col_width)
            8'd8:    int_ok = i_in.value != db_vtf_pkg::INT_NULL_8;
            8'd4:    int_ok = i_in.value != db_vtf_pkg::INT_NULL_4;
            8'd2:    int_ok = i_in.value != db_vtf_pkg::INT_NULL_2;
            8'd1:    int_ok = i_in.value != db_vtf_pkg::INT_NULL_1;
            default: int_ok = 1'b0;
        endcase
    end

    always_comb begin
        o_desc.mode  = db_vtf_pkg::MODE_NONE;
        o_desc.neg   = 1'b0;
        o_desc.value = i_in.value;
        o_desc.count = i_in.col_width[3:0];
        o_desc.scale = 5'd0;
        case (i_in.col_kind)
            db_vtf_pkg::KIND_NULL: begin
            end
            db_vtf_pkg::KIND_DATE: begin
                if (i_in.value != db_vtf_pkg::DATE_NULL) o_desc.mode = db_vtf_pkg::MODE_DATE;
            end
            db_vtf_pkg::KIND_DTIME: begin
                if (i_in.value != db_vtf_pkg::DTIME_NULL) o_desc.mode = db_vtf_pkg::MODE_DTIME;
            end
            db_vtf_pkg::KIND_CHAR, db_vtf_pkg::KIND_VARCHAR: begin
                if (i_in.col_width inside {[8'd1:8'd8]}) begin
                    if (i_in.value != chr_null) o_desc.mode = db_vtf_pkg::MODE_CHARS;
                end else begin
                    // Char columns outside widths 1 to 8 print as plain signed decimal.
                    o_desc.mode  = db_vtf_pkg::MODE_DEC;
                    o_desc.neg   = i_in.value[63];
                    o_desc.value = mag;
                end
            end
            default: begin
                if (int_ok) begin
                    o_desc.mode  = db_vtf_pkg::MODE_DEC;
                    o_desc.neg   = i_in.value[63];
                    o_desc.value = mag;
                    o_desc.scale = (i_in.scale > db_vtf_pkg::SCALE_MAX) ?
                                   db_vtf_pkg::SCALE_MAX : i_in.scale;
                end
            end
        endcase
    end

endmodule

[hdl/db_vtf_queue.sv]
// Two-entry descriptor queue between the front and back ends.
module db_vtf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  db_vtf_pkg::t_desc  i_wdata,
    output logic               o_full,
    input  logic               i_pop,
    output db_vtf_pkg::t_desc  o_rdata,
    output logic               o_empty
);

    db_vtf_pkg::t_desc r_mem [2];
    logic              r_wptr, r_rptr;
    logic [1:0]        r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

[hdl/db_vtf_back.sv]
// Back end: bit-serial binary to BCD conversion and byte-wise text emission.
`include "db_value_to_text_formatter_defines.svh"
module db_vtf_back #(
    parameter int MAX_CHARS = 22
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  db_vtf_pkg::t_desc  i_desc,
    input  logic               i_empty,
    output logic               o_pop,
    input  logic [7:0]         i_separator,
    db_vtf_out_if.source       o_out
);

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int BW = db_vtf_pkg::BCD_W;

    db_vtf_pkg::t_state r_state, n_state;
    db_vtf_pkg::t_mode  r_mode;
    logic               r_neg, n_neg;
    logic [63:0]        r_value, n_value;
    logic [63:0]        r_bin, n_bin;
    logic [BW-1:0]      r_bcd, n_bcd;
    logic [5:0]         r_iter, n_iter;
    logic [4:0]         r_pos, n_pos;
    logic [3:0]         r_count;
    logic [4:0]         r_scale;
    logic               r_point, n_point;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_out_byte, n_out_byte;
    logic               r_out_last, n_out_last;

    logic       out_free, emit, cap_hit, skip_more, text_done;
    logic [7:0] text_byte, date_byte, y_hi;
    logic [5:0] p_day, p_hr, p_min, p_sec;
    logic [3:0] p_mon;
    logic [3:0] top_digit;

    assign out_free  = !r_out_valid || o_out.ready;
    assign emit      = (r_state == db_vtf_pkg::ST_TEXT || r_state == db_vtf_pkg::ST_SEP)
                       && out_free;
    assign cap_hit   = r_cnt == CW'(MAX_CHARS - 1);
    assign top_digit = r_bcd[BW-1 -: 4];
    assign skip_more = (top_digit == 4'd0) && (r_pos != 5'd0) && (r_pos >= r_scale);
    assign o_pop     = (r_state == db_vtf_pkg::ST_IDLE) && !i_empty;

    assign o_out.valid     = r_out_valid;
    assign o_out.char_byte = r_out_byte;
    assign o_out.last      = r_out_last;

    // Date parts; the year comes out of the converter as five BCD digits.
    always_comb begin
        if (r_mode == db_vtf_pkg::MODE_DATE) begin
            p_day = r_value[11:6];
            p_mon = r_value[15:12];
        end else begin
            p_day = r_value[43:38];
            p_mon = r_value[47:44];
        end
        p_sec = r_value[25:20];
        p_min = r_value[31:26];
        p_hr  = r_value[37:32];
        y_hi  = {4'd0, r_bcd[19:16]} * 8'd10 + {4'd0, r_bcd[15:12]};
    end

    always_comb begin
        case (r_pos)
            5'd0:    date_byte = db_vtf_pkg::ASCII_0 + y_hi;
            5'd1:    date_byte = db_vtf_pkg::ASCII_0 + {4'd0, r_bcd[11:8]};
            5'd2:    date_byte = db_vtf_pkg::ASCII_0 + {4'd0, r_bcd[7:4]};
            5'd3:    date_byte = db_vtf_pkg::ASCII_0 + {4'd0, r_bcd[3:0]};
            5'd4:    date_byte = db_vtf_pkg::ASCII_DASH;
            5'd5:    date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::tens6({2'd0, p_mon})};
            5'd6:    date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::ones6({2'd0, p_mon})};
            5'd7:    date_byte = db_vtf_pkg::ASCII_DASH;
            5'd8:    date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::tens6(p_day)};
            5'd9:    date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::ones6(p_day)};
            5'd10:   date_byte = db_vtf_pkg::ASCII_SPACE;
            5'd11:   date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::tens6(p_hr)};
            5'd12:   date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::ones6(p_hr)};
            5'd13:   date_byte = db_vtf_pkg::ASCII_COLON;
            5'd14:   date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::tens6(p_min)};
            5'd15:   date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::ones6(p_min)};
            5'd16:   date_byte = db_vtf_pkg::ASCII_COLON;
            5'd17:   date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::tens6(p_sec)};
            default: date_byte = db_vtf_pkg::ASCII_0 + {4'd0, db_vtf_pkg::ones6(p_sec)};
        endcase
    end

    always_comb begin
        case (r_mode)
            db_vtf_pkg::MODE_DATE: begin
                text_byte = date_byte;
                text_done = r_pos == 5'd9;
            end
            db_vtf_pkg::MODE_DTIME: begin
                text_byte = date_byte;
                text_done = r_pos == 5'd18;
            end
            db_vtf_pkg::MODE_CHARS: begin
                text_byte = r_value[7:0];
                text_done = r_pos == (5'(r_count) - 5'd1);
            end
            db_vtf_pkg::MODE_DEC: begin
                if (r_neg) begin
                    text_byte = db_vtf_pkg::ASCII_DASH;
                    text_done = 1'b0;
                end else if (r_scale != 5'd0 && r_pos == r_scale - 5'd1 && !r_point) begin
                    text_byte = db_vtf_pkg::ASCII_DOT;
                    text_done = 1'b0;
                end else begin
                    text_byte = db_vtf_pkg::ASCII_0 + {4'd0, top_digit};
                    text_done = r_pos == 5'd0;
                end
            end
            default: begin
                text_byte = i_separator;
                text_done = 1'b1;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            db_vtf_pkg::ST_IDLE: begin
                if (!i_empty) begin
                    case (i_desc.mode)
                        db_vtf_pkg::MODE_DATE, db_vtf_pkg::MODE_DTIME,
                        db_vtf_pkg::MODE_DEC:   n_state = db_vtf_pkg::ST_CONV;
                        db_vtf_pkg::MODE_CHARS: n_state = db_vtf_pkg::ST_TEXT;
                        default:                n_state = db_vtf_pkg::ST_SEP;
                    endcase
                end
            end
            db_vtf_pkg::ST_CONV: begin
                if (r_iter == 6'd0) begin
                    n_state = (r_mode == db_vtf_pkg::MODE_DEC) ?
                              db_vtf_pkg::ST_SKIP : db_vtf_pkg::ST_TEXT;
                end
            end
            db_vtf_pkg::ST_SKIP: begin
                if (!skip_more) n_state = db_vtf_pkg::ST_TEXT;
            end
            db_vtf_pkg::ST_TEXT: begin
                if (emit) begin
                    if (cap_hit)        n_state = db_vtf_pkg::ST_IDLE;
                    else if (text_done) n_state = db_vtf_pkg::ST_SEP;
                end
            end
            db_vtf_pkg::ST_SEP: begin
                if (out_free) n_state = db_vtf_pkg::ST_IDLE;
            end
            default: n_state = db_vtf_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output register.
    always_comb begin
        n_neg       = r_neg;
        n_value     = r_value;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_iter      = r_iter;
        n_pos       = r_pos;
        n_point     = r_point;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        case (r_state)
            db_vtf_pkg::ST_IDLE: begin
                n_neg   = i_desc.neg;
                n_value = i_desc.value;
                n_bcd   = '0;
                n_point = 1'b0;
                n_cnt   = '0;
                case (i_desc.mode)
                    db_vtf_pkg::MODE_DATE: n_bin = {i_desc.value[31:16], 48'd0};
                    db_vtf_pkg::MODE_DTIME: n_bin = {i_desc.value[63:48], 48'd0};
                    default:               n_bin = i_desc.value;
                endcase
                n_iter = (i_desc.mode == db_vtf_pkg::MODE_DEC) ? 6'd63 : 6'd15;
                n_pos  = (i_desc.mode == db_vtf_pkg::MODE_DEC) ?
                         5'(db_vtf_pkg::BCD_DIGITS - 1) : 5'd0;
            end
            db_vtf_pkg::ST_CONV: begin
                {n_bcd, n_bin} = {db_vtf_pkg::bcd_adjust(r_bcd), r_bin} << 1;
                n_iter = r_iter - 6'd1;
            end
            db_vtf_pkg::ST_SKIP: begin
                if (skip_more) begin
                    n_bcd = r_bcd << 4;
                    n_pos = r_pos - 5'd1;
                end
            end
            db_vtf_pkg::ST_TEXT: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = text_byte;
                    n_out_last  = cap_hit;
                    n_cnt       = r_cnt + CW'(1);
                    case (r_mode)
                        db_vtf_pkg::MODE_CHARS: begin
                            n_value = r_value >> 8;
                            n_pos   = r_pos + 5'd1;
                        end
                        db_vtf_pkg::MODE_DEC: begin
                            if (r_neg) begin
                                n_neg = 1'b0;
                            end else if (text_byte == db_vtf_pkg::ASCII_DOT && !r_point) begin
                                n_point = 1'b1;
                            end else begin
                                n_bcd = r_bcd << 4;
                                n_pos = r_pos - 5'd1;
                            end
                        end
                        default: n_pos = r_pos + 5'd1;
                    endcase
                end
            end
            db_vtf_pkg::ST_SEP: begin
                if (emit) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = i_separator;
                    n_out_last  = 1'b1;
                    n_cnt       = r_cnt + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= db_vtf_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_iter      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_iter      <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mode  <= i_desc.mode;
            r_count <= i_desc.count;
            r_scale <= i_desc.scale;
        end
        r_neg      <= n_neg;
        r_value    <= n_value;
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_pos      <= n_pos;
        r_point    <= n_point;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    `VTF_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_CHARS), "field exceeds buffer")
    `VTF_ASSERT(a_conv_end, i_clk, i_rst_n, (r_state == db_vtf_pkg::ST_CONV && r_iter == 6'd0) |=> (r_state != db_vtf_pkg::ST_CONV), "converter overran")
    `VTF_ASSERT(a_sep_last, i_clk, i_rst_n, (r_state == db_vtf_pkg::ST_SEP && out_free) |=> (r_out_valid && r_out_last), "separator not flagged last")

endmodule

[hdl/db_value_to_text_formatter.sv]
// An accepted item is written to the queue and fetched by the back end when it is idle; a date,
// datetime or decimal is converted to BCD first, and a decimal has its leading zeros stripped.
// Later bytes follow one per cycle while the output is ready. The back end takes one item at a time
// (fetch, up to 64 converter steps, leading zeros, bytes, separator).
// The queue holds two more items, so the input stalls only while it is full.
// Reset is synchronous, active low: queue empty, back end idle, separator set to ','.
module db_value_to_text_formatter #(
    parameter int MAX_FIELD_CHARS = 22
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    db_vtf_in_if.sink    i_in,
    db_vtf_out_if.source o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [7:0]        r_separator;
    logic              push, pop, full, empty;
    db_vtf_pkg::t_desc desc_in, desc_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == db_vtf_pkg::REG_SEPARATOR) ? {24'd0, r_separator} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator <= db_vtf_pkg::SEP_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == db_vtf_pkg::REG_SEPARATOR) begin
            r_separator <= pwdata[7:0];
        end
    end

    db_vtf_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_desc (desc_in)
    );

    db_vtf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (desc_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_rdata (desc_out),
        .o_empty (empty)
    );

    db_vtf_back #(
        .MAX_CHARS (MAX_FIELD_CHARS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (desc_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_separator (r_separator),
        .o_out       (o_out)
    );

endmodule
